>>> rtl/rcf_pkg.sv
// Package for the regional cubic field model: widths, datapath constants,
// the monomial schedule and the control struct of the shared multiply unit.
// Depends on nothing; the interfaces, the top level, rcf_mac and the testbench import it.
`default_nettype none

package rcf_pkg;

  localparam int AREAS_DEF      = 8;
  localparam int WORDS_PER_AREA = 24;
  localparam int WORD_W         = 64;
  localparam int TADDR_W        = 8;
  localparam int LON_W          = 25;
  localparam int LAT_W          = 24;
  localparam int RES_W          = 25;
  localparam int IDX_W          = 3;
  localparam int CFG_W          = 4;
  localparam int CNT_W          = 5;   // holds region counts up to 16
  localparam int OFF_W          = 5;   // word offset inside one region
  localparam int MONO_W         = 76;  // largest monomial is below 2^73 in size
  localparam int DIG_W          = 16;  // multiplier digit of the B operand
  localparam int ACC_W          = 144; // exact sum of ten coefficient products
  localparam int NMONO          = 10;
  localparam int MIDX_W         = 4;
  localparam int OP_W           = 3;
  localparam int NOPS           = 7;
  localparam int FRAC_SHIFT     = 72;  // Q88 sum down to Q16

  // Word offsets within one region.
  localparam logic [OFF_W-1:0] W_WEST  = OFF_W'(0);
  localparam logic [OFF_W-1:0] W_EAST  = OFF_W'(1);
  localparam logic [OFF_W-1:0] W_SOUTH = OFF_W'(2);
  localparam logic [OFF_W-1:0] W_NORTH = OFF_W'(3);
  localparam logic [OFF_W-1:0] W_DECL  = OFF_W'(4);
  localparam logic [OFF_W-1:0] W_INCL  = OFF_W'(14);

  localparam logic [1:0] TOP_POS  = 2'd1; // position operand spans two digits
  localparam logic [1:0] TOP_COEF = 2'd3; // coefficient spans four digits

  localparam logic       FUNC_WRITE = 1'b0;
  localparam logic       FUNC_EVAL  = 1'b1;

  typedef struct packed {
    logic       clr;
    logic       load;
    logic       step;
    logic [1:0] top;
  } mac_ctl_t;

  typedef struct packed {
    logic [MIDX_W-1:0] aidx;
    logic              b_is_y;
    logic [MIDX_W-1:0] dest;
  } mono_op_t;

  // Each step multiplies a stored monomial by x or y and keeps the product
  // shifted right by 16, which is exact since the operand carries 2^16 or more.
  function automatic mono_op_t mono_op(input logic [OP_W-1:0] op);
    mono_op_t r;
    unique case (op)
      3'd0:    r = '{aidx: 4'd8, b_is_y: 1'b0, dest: 4'd7}; // x^2 * 2^16
      3'd1:    r = '{aidx: 4'd8, b_is_y: 1'b1, dest: 4'd4}; // x*y * 2^16
      3'd2:    r = '{aidx: 4'd5, b_is_y: 1'b1, dest: 4'd2}; // y^2 * 2^16
      3'd3:    r = '{aidx: 4'd7, b_is_y: 1'b0, dest: 4'd6}; // x^3
      3'd4:    r = '{aidx: 4'd7, b_is_y: 1'b1, dest: 4'd3}; // x^2*y
      3'd5:    r = '{aidx: 4'd2, b_is_y: 1'b0, dest: 4'd1}; // x*y^2
      3'd6:    r = '{aidx: 4'd2, b_is_y: 1'b1, dest: 4'd0}; // y^3
      default: r = '{aidx: 4'd8, b_is_y: 1'b0, dest: 4'd7};
    endcase
    return r;
  endfunction

  // Floor to Q16 and saturate to the signed result range.
  function automatic logic [RES_W-1:0] sat_q16(input logic signed [ACC_W-1:0] s);
    logic [RES_W-1:0] r;
    logic             fits;
    fits = (s[ACC_W-1:FRAC_SHIFT+RES_W-1] == {(ACC_W-FRAC_SHIFT-RES_W+1){s[ACC_W-1]}});
    if (fits) begin
      r = s[FRAC_SHIFT+RES_W-1:FRAC_SHIFT];
    end else if (s[ACC_W-1]) begin
      r = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(RES_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rcf_in_if.sv
// Input channel of the regional cubic field model: valid/ready and one item.
// Depends on rcf_pkg for the field widths.
`default_nettype none

interface rcf_in_if import rcf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [TADDR_W-1:0]       table_address;
  logic signed [WORD_W-1:0] table_word;
  logic signed [LON_W-1:0]  longitude;
  logic signed [LAT_W-1:0]  latitude;

  modport source (output valid, func, table_address, table_word, longitude, latitude,
                  input ready);
  modport sink (input valid, func, table_address, table_word, longitude, latitude,
                output ready);
endinterface

`default_nettype wire

>>> rtl/rcf_out_if.sv
// Result channel of the regional cubic field model: valid/ready and one result.
// Depends on rcf_pkg for the field widths.
`default_nettype none

interface rcf_out_if import rcf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] declination;
  logic signed [RES_W-1:0] inclination;
  logic                    valid_res;
  logic [IDX_W-1:0]        area_index;

  modport source (output valid, declination, inclination, valid_res, area_index,
                  input ready);
  modport sink (input valid, declination, inclination, valid_res, area_index,
                output ready);
endinterface

`default_nettype wire

>>> rtl/regional_cubic_field_model.sv
// Regional cubic field model. Table words are written one per transaction. An
// evaluate transaction checks the regions in use from index 0 upward, each bound
// by a read from the table RAM and then a compare, and leaves a region at its
// first failing bound. On a match it forms the monomials and then the two
// ten-term cubics on one shared 76x17 multiplier. The result waits in an output
// register. Depends on rcf_pkg, rcf_in_if, rcf_out_if, rcf_ram and rcf_mac.
`default_nettype none

module regional_cubic_field_model import rcf_pkg::*; #(
  parameter int AREAS = AREAS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  rcf_in_if.sink                in_chan,
  rcf_out_if.source             out_chan,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int DEPTH = AREAS * WORDS_PER_AREA;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_BRD  = 11'b00000000010,
    S_BCMP = 11'b00000000100,
    S_MLD  = 11'b00000001000,
    S_MMUL = 11'b00000010000,
    S_MWB  = 11'b00000100000,
    S_CRD  = 11'b00001000000,
    S_CLD  = 11'b00010000000,
    S_CMUL = 11'b00100000000,
    S_CNX  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         cfg_r;
  logic [CNT_W-1:0]         lim;
  logic [CNT_W-1:0]         area_r, area_nxt;
  logic [AW-1:0]            base_r;
  logic [1:0]               bw_r;
  logic [OP_W-1:0]          op_r;
  logic [MIDX_W-1:0]        k_r;
  logic                     cub_r;
  logic signed [LON_W-1:0]  lon_r;
  logic signed [LAT_W-1:0]  lat_r;
  logic signed [MONO_W-1:0] mono_r [NMONO];
  logic                     found_r;
  logic [RES_W-1:0]         decl_r, incl_r;

  logic                     in_acc, out_acc, ld_out, wr_ok, bnd_fail;
  logic [OFF_W-1:0]         off;
  logic [AW-1:0]            raddr;
  logic [WORD_W-1:0]        rdata;
  logic signed [WORD_W-1:0] rword, lon_w, lat_w;
  mono_op_t                 mop;
  mac_ctl_t                 mctl;
  logic signed [MONO_W-1:0] a_in;
  logic signed [WORD_W-1:0] b_in;
  logic signed [ACC_W-1:0]  acc;
  logic                     last;

  logic                     ov_r;
  logic signed [RES_W-1:0]  od_r, oi_r;
  logic                     ovr_r;
  logic [IDX_W-1:0]         oidx_r;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_acc       = ov_r && out_chan.ready;
  assign ld_out        = (state_r == S_OUT) && (!ov_r || out_chan.ready);

  assign lim  = (CNT_W'(cfg_r) > CNT_W'(AREAS)) ? CNT_W'(AREAS) : CNT_W'(cfg_r);
  assign area_nxt = area_r + CNT_W'(1);
  assign wr_ok    = (32'(in_chan.table_address) < 32'(DEPTH));

  assign mop   = mono_op(op_r);
  assign rword = $signed(rdata);
  assign lon_w = WORD_W'(lon_r);
  assign lat_w = WORD_W'(lat_r);

  always_comb begin
    if (state_r == S_BRD) begin
      off = OFF_W'(bw_r);
    end else begin
      off = (cub_r ? W_INCL : W_DECL) + OFF_W'(k_r);
    end
    raddr = base_r + AW'(off);
  end

  rcf_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (in_acc && (in_chan.func == FUNC_WRITE) && wr_ok),
    .waddr (AW'(in_chan.table_address)),
    .wdata (in_chan.table_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  // West, east, south and north bounds, inclusive.
  always_comb begin
    unique case (bw_r)
      2'd0:    bnd_fail = lon_w < rword;
      2'd1:    bnd_fail = lon_w > rword;
      2'd2:    bnd_fail = lat_w < rword;
      default: bnd_fail = lat_w > rword;
    endcase
  end

  always_comb begin
    mctl      = '0;
    a_in      = mono_r[(state_r == S_MMUL) ? mop.aidx : k_r];
    b_in      = rword;
    if (state_r == S_MLD) begin
      mctl.load = 1'b1;
      mctl.clr  = 1'b1;
      mctl.top  = TOP_POS;
      b_in      = mop.b_is_y ? lat_w : lon_w;
    end else if (state_r == S_CLD) begin
      mctl.load = 1'b1;
      mctl.clr  = (k_r == '0);
      mctl.top  = TOP_COEF;
    end else if ((state_r == S_MMUL) || (state_r == S_CMUL)) begin
      mctl.step = 1'b1;
    end
  end

  rcf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .a_in  (a_in),
    .b_in  (b_in),
    .acc   (acc),
    .last  (last)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && (in_chan.func == FUNC_EVAL)) begin
        state_nxt = (lim == '0) ? S_OUT : S_BRD;
      end
      S_BRD:  state_nxt = S_BCMP;
      S_BCMP: begin
        if (bnd_fail) begin
          state_nxt = (area_nxt >= lim) ? S_OUT : S_BRD;
        end else begin
          state_nxt = (bw_r == 2'd3) ? S_MLD : S_BRD;
        end
      end
      S_MLD:  state_nxt = S_MMUL;
      S_MMUL: if (last) state_nxt = S_MWB;
      S_MWB:  state_nxt = (op_r == OP_W'(NOPS - 1)) ? S_CRD : S_MLD;
      S_CRD:  state_nxt = S_CLD;
      S_CLD:  state_nxt = S_CMUL;
      S_CMUL: if (last) state_nxt = S_CNX;
      S_CNX:  state_nxt = ((k_r == MIDX_W'(NMONO - 1)) && cub_r) ? S_OUT : S_CRD;
      S_OUT:  if (ld_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cfg_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (ld_out) begin
        ov_r <= 1'b1;
      end else if (out_acc) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        lon_r   <= in_chan.longitude;
        lat_r   <= in_chan.latitude;
        area_r  <= '0;
        base_r  <= '0;
        bw_r    <= '0;
        found_r <= 1'b0;
      end
      S_BCMP: begin
        if (bnd_fail) begin
          area_r <= area_nxt;
          base_r <= base_r + AW'(WORDS_PER_AREA);
          bw_r   <= '0;
        end else if (bw_r == 2'd3) begin
          found_r   <= 1'b1;
          op_r      <= '0;
          mono_r[9] <= MONO_W'(1) <<< 48;
          mono_r[8] <= MONO_W'(lon_r) <<< 32;
          mono_r[5] <= MONO_W'(lat_r) <<< 32;
        end else begin
          bw_r <= bw_r + 2'd1;
        end
      end
      S_MWB: begin
        mono_r[mop.dest] <= MONO_W'(acc >>> DIG_W);
        op_r  <= op_r + OP_W'(1);
        k_r   <= '0;
        cub_r <= 1'b0;
      end
      S_CNX: begin
        if (k_r == MIDX_W'(NMONO - 1)) begin
          k_r   <= '0;
          cub_r <= 1'b1;
          if (cub_r) begin
            incl_r <= sat_q16(acc);
          end else begin
            decl_r <= sat_q16(acc);
          end
        end else begin
          k_r <= k_r + MIDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      ovr_r  <= found_r;
      od_r   <= found_r ? $signed(decl_r) : '0;
      oi_r   <= found_r ? $signed(incl_r) : '0;
      oidx_r <= found_r ? area_r[IDX_W-1:0] : '0;
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.declination = od_r;
  assign out_chan.inclination = oi_r;
  assign out_chan.valid_res   = ovr_r;
  assign out_chan.area_index  = oidx_r;

endmodule

`default_nettype wire

>>> rtl/rcf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none

module rcf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 192,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/rcf_mac.sv
// Shared multiply-accumulate unit: a wide signed operand times one 16-bit
// digit of a held 64-bit operand per stepped cycle, summed into an exact accumulator.
// Depends on rcf_pkg.
`default_nettype none

module rcf_mac import rcf_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [MONO_W-1:0] a_in,
  input  wire logic signed [WORD_W-1:0] b_in,
  output logic signed [ACC_W-1:0]       acc,
  output logic                          last
);

  logic [WORD_W-1:0]             b_r;
  logic [1:0]                    dig_r, dig_nxt;
  logic [1:0]                    top_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic [DIG_W-1:0]              dlo;
  logic signed [DIG_W:0]         dval;
  logic signed [MONO_W+DIG_W:0]  prod;
  logic signed [ACC_W-1:0]       pext, pshift;

  always_comb begin
    dlo  = b_r[dig_r*DIG_W +: DIG_W];
    // Only the top digit carries the sign; the lower ones are unsigned.
    dval = $signed({(dig_r == top_r) & dlo[DIG_W-1], dlo});
    prod = a_in * dval;
    pext = ACC_W'(prod);
    unique case (dig_r)
      2'd0:    pshift = pext;
      2'd1:    pshift = pext <<< DIG_W;
      2'd2:    pshift = pext <<< (2 * DIG_W);
      default: pshift = pext <<< (3 * DIG_W);
    endcase
    dig_nxt = dig_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_r <= '0;
      top_r <= '0;
    end else if (ctl.load) begin
      dig_r <= '0;
      top_r <= ctl.top;
    end else if (ctl.step) begin
      dig_r <= dig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      b_r <= b_in;
      if (ctl.clr) begin
        acc_r <= '0;
      end
    end else if (ctl.step) begin
      acc_r <= acc_r + pshift;
    end
  end

  assign acc  = acc_r;
  assign last = (dig_r == top_r);

endmodule

`default_nettype wire

>>> sim/regional_cubic_field_model_test.sv
// Testbench for regional_cubic_field_model: loads the region table, evaluates
// positions against its own fixed-point predictor, with random idling on both sides.
// Depends on rcf_pkg, rcf_in_if, rcf_out_if and the block's RTL.
`default_nettype none

module regional_cubic_field_model_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rcf_pkg::*;

  localparam int          N_WORDS = AREAS_DEF * WORDS_PER_AREA;
  localparam longint      LON_MAX = 11796480;
  localparam longint      LAT_MAX = 5898240;
  localparam longint      DEG     = 65536;
  localparam int          LIMIT   = 2000000;
  localparam int          SETTLE  = 300;

  typedef struct {
    logic signed [RES_W-1:0] decl;
    logic signed [RES_W-1:0] incl;
    logic                    hit;
    logic [IDX_W-1:0]        idx;
  } fix_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  rcf_in_if  in_chan();
  rcf_out_if out_chan();

  regional_cubic_field_model dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor state: the table as the block should hold it and the region count.
  logic signed [WORD_W-1:0] area_words [N_WORDS];
  logic [CFG_W-1:0]         areas_used;
  fix_t                     pending_fixes [$];
  fix_t                     want;

  int errors, cycles, n_writes, n_evals, n_hits, n_sat;
  int burst_left;
  bit gaps_on;
  int hold_req, hold_left, rx_mode, rx_window;

  function automatic logic signed [RES_W-1:0] cubic_q16(input int base,
                                                       input logic signed [191:0] m [10]);
    logic signed [191:0] acc;
    logic signed [191:0] c;
    acc = '0;
    for (int k = 0; k < NMONO; k++) begin
      c = area_words[base + k];
      acc = acc + c * m[k];
    end
    acc = acc >>> FRAC_SHIFT;
    if (acc > $signed(192'd16777215)) return {1'b0, {(RES_W-1){1'b1}}};
    if (acc < -$signed(192'd16777216)) return {1'b1, {(RES_W-1){1'b0}}};
    return acc[RES_W-1:0];
  endfunction

  function automatic fix_t locate_fix(input logic signed [LON_W-1:0] lon,
                                      input logic signed [LAT_W-1:0] lat);
    fix_t                f;
    int                  n, b;
    logic signed [191:0] x, y;
    logic signed [191:0] m [10];
    f = '{decl: '0, incl: '0, hit: 1'b0, idx: '0};
    n = (areas_used > AREAS_DEF) ? AREAS_DEF : int'(areas_used);
    for (int a = 0; a < n; a++) begin
      b = a * WORDS_PER_AREA;
      if (lon < area_words[b] || lon > area_words[b + 1]) continue;
      if (lat < area_words[b + 2] || lat > area_words[b + 3]) continue;
      x = lon;
      y = lat;
      m[9] = 1;
      m[9] = m[9] <<< 48;
      m[8] = x <<< 32;
      m[7] = (x * x) <<< 16;
      m[6] = x * x * x;
      m[5] = y <<< 32;
      m[4] = (x * y) <<< 16;
      m[3] = x * x * y;
      m[2] = (y * y) <<< 16;
      m[1] = x * y * y;
      m[0] = y * y * y;
      f.decl = cubic_q16(b + W_DECL, m);
      f.incl = cubic_q16(b + W_INCL, m);
      f.hit  = 1'b1;
      f.idx  = a[IDX_W-1:0];
      return f;
    end
    return f;
  endfunction

  // Follows every accepted input transaction.
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      if (in_chan.func == FUNC_WRITE) begin
        if (in_chan.table_address < N_WORDS) area_words[in_chan.table_address] = in_chan.table_word;
        n_writes++;
      end else begin
        pending_fixes.push_back(locate_fix(in_chan.longitude, in_chan.latitude));
        n_evals++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_fixes.size() == 0) begin
        $error("result transaction with no evaluation pending");
        errors++;
      end else begin
        want = pending_fixes.pop_front();
        if (out_chan.declination !== want.decl) begin
          $error("declination: expected %0d, got %0d", want.decl, out_chan.declination);
          errors++;
        end
        if (out_chan.inclination !== want.incl) begin
          $error("inclination: expected %0d, got %0d", want.incl, out_chan.inclination);
          errors++;
        end
        if (out_chan.valid_res !== want.hit) begin
          $error("valid_res: expected %0d, got %0d", want.hit, out_chan.valid_res);
          errors++;
        end
        if (out_chan.area_index !== want.idx) begin
          $error("area_index: expected %0d, got %0d", want.idx, out_chan.area_index);
          errors++;
        end
        if (want.hit) n_hits++;
        if (want.decl == 25'h0FFFFFF || want.decl == 25'h1000000) n_sat++;
      end
    end
  end

  // Receiver: switches among always ready, light and heavy stalls; a hold-off
  // request keeps it stalled for a counted stretch.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rx_window == 0) begin
      rx_mode   = $urandom_range(2);
      rx_window = $urandom_range(20, 200);
    end else begin
      rx_window--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_chan.ready <= 1'b1;
        1:       out_chan.ready <= ($urandom_range(3) != 0);
        default: out_chan.ready <= ($urandom_range(1) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
  endfunction

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
  endfunction

  // Coefficients of random bit length so that results spread from tiny to saturated.
  function automatic logic signed [WORD_W-1:0] rand_coef();
    int          len;
    logic [63:0] v;
    len = $urandom_range(1, 64);
    v   = {$urandom, $urandom};
    if (len < 64) v = v & ((64'd1 << len) - 64'd1);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // Called at a clock edge; returns at the edge where the item was taken, or after the gap that ends a burst.
  // Valid stays high within a burst, so the next call must follow without delay.
  task automatic send_item(input logic func, input logic [TADDR_W-1:0] addr,
                           input logic signed [WORD_W-1:0] word,
                           input longint lon, input longint lat);
    in_chan.func          <= func;
    in_chan.table_address <= addr;
    in_chan.table_word    <= word;
    in_chan.longitude     <= lon[LON_W-1:0];
    in_chan.latitude      <= lat[LAT_W-1:0];
    in_chan.valid         <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_chan.valid <= 1'b0;
        burst_left = $urandom_range(1, 24);
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_word(input int addr, input logic signed [WORD_W-1:0] word);
    send_item(FUNC_WRITE, addr[TADDR_W-1:0], word, rand_lon(), rand_lat());
  endtask

  task automatic eval_at(input longint lon, input longint lat);
    send_item(FUNC_EVAL, TADDR_W'($urandom), {$urandom, $urandom}, lon, lat);
  endtask

  task automatic write_bounds(input int r, input longint w, input longint e,
                              input longint s, input longint n);
    write_word(r * WORDS_PER_AREA + W_WEST, w);
    write_word(r * WORDS_PER_AREA + W_EAST, e);
    write_word(r * WORDS_PER_AREA + W_SOUTH, s);
    write_word(r * WORDS_PER_AREA + W_NORTH, n);
  endtask

  // Extreme coefficients: declination all most positive, inclination all most negative.
  task automatic write_coefs(input int r, input bit extreme);
    for (int k = 0; k < 2 * NMONO; k++) begin
      if (!extreme) write_word(r * WORDS_PER_AREA + W_DECL + k, rand_coef());
      else if (k < NMONO) write_word(r * WORDS_PER_AREA + W_DECL + k, 64'sh7FFF_FFFF_FFFF_FFFF);
      else write_word(r * WORDS_PER_AREA + W_DECL + k, 64'sh8000_0000_0000_0000);
    end
  endtask

  task automatic load_random_region(input int r);
    longint a, b, c, d;
    a = rand_lon();
    b = rand_lon();
    c = rand_lat();
    d = rand_lat();
    if ($urandom_range(5) == 0) write_bounds(r, -LON_MAX, LON_MAX, -LAT_MAX, LAT_MAX);
    else write_bounds(r, (a < b) ? a : b, (a < b) ? b : a, (c < d) ? c : d, (c < d) ? d : c);
    write_coefs(r, 1'b0);
  endtask

  // Picks a coordinate near [lo, hi] clipped to the legal range: often on an edge or just outside it, else inside it.
  function automatic longint pick_coord(input longint lo, input longint hi, input longint lim);
    longint l, h;
    l = (lo < -lim) ? -lim : lo;
    h = (hi > lim) ? lim : hi;
    if (l > h) return longint'($urandom_range(0, 2 * lim)) - lim;
    case ($urandom_range(5))
      0:       return l;
      1:       return h;
      2:       return (l > -lim) ? l - 1 : l;
      3:       return (h < lim) ? h + 1 : h;
      default: return l + longint'($urandom_range(0, h - l));
    endcase
  endfunction

  task automatic eval_random();
    int r, n;
    n = (areas_used > AREAS_DEF) ? AREAS_DEF : int'(areas_used);
    if (n > 0 && $urandom_range(3) != 0) begin
      r = $urandom_range(0, n - 1) * WORDS_PER_AREA;
      eval_at(pick_coord(area_words[r], area_words[r + 1], LON_MAX),
              pick_coord(area_words[r + 2], area_words[r + 3], LAT_MAX));
    end else begin
      eval_at(rand_lon(), rand_lat());
    end
  endtask

  task automatic drop_valid();
    in_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes produce no result, so a fixed settle follows the drain.
  task automatic wait_idle();
    drop_valid();
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_areas(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we     <= 1'b0;
    areas_used = v[CFG_W-1:0];
  endtask

  task automatic test_table_load();
    gaps_on = 1'b1;
    write_bounds(0, -10 * DEG, 10 * DEG, -10 * DEG, 10 * DEG);
    write_coefs(0, 1'b0);
    write_bounds(1, 20 * DEG, 40 * DEG, -5 * DEG, 30 * DEG);
    write_coefs(1, 1'b0);
    for (int r = 2; r < 6; r++) load_random_region(r);
    write_bounds(6, -LON_MAX, LON_MAX, -LAT_MAX, LAT_MAX);
    write_coefs(6, 1'b1);
    write_bounds(7, -LON_MAX, LON_MAX, -LAT_MAX, LAT_MAX);
    write_coefs(7, 1'b0);
  endtask

  task automatic test_directed();
    wait_idle();
    set_areas(15);
    gaps_on = 1'b0;
    eval_at(0, 0);
    eval_at(10 * DEG, 10 * DEG);
    eval_at(-10 * DEG, -10 * DEG);
    eval_at(10 * DEG + 1, 0);
    eval_at(20 * DEG, -5 * DEG);
    eval_at(40 * DEG, 30 * DEG);
    eval_at(20 * DEG - 1, -5 * DEG);
    eval_at(LON_MAX, LAT_MAX);
    eval_at(-LON_MAX, -LAT_MAX);
    eval_at(LON_MAX, -LAT_MAX);
    eval_at(-LON_MAX, LAT_MAX);
    // Addresses past the table must leave it untouched.
    write_word(N_WORDS, 64'sh7FFF_FFFF_FFFF_FFFF);
    write_word(255, 64'sh8000_0000_0000_0000);
    eval_at(0, 0);
    wait_idle();
    set_areas(0);
    eval_at(0, 0);
    wait_idle();
    set_areas(1);
    eval_at(50 * DEG, 50 * DEG);
    eval_at(-10 * DEG, 10 * DEG);
  endtask

  task automatic test_random_phases();
    int plan [10] = '{8, 3, 15, 1, 8, 6, 12, 2, 8, 4};
    foreach (plan[p]) begin
      wait_idle();
      set_areas(plan[p]);
      gaps_on = ($urandom_range(3) != 0);
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(99)) inside
          [0:1]:   load_random_region($urandom_range(0, AREAS_DEF - 1));
          [2:6]:   write_word($urandom_range(0, 255), rand_coef());
          default: eval_random();
        endcase
      end
    end
  endtask

  task automatic test_output_hold();
    wait_idle();
    set_areas(8);
    gaps_on  = 1'b0;
    hold_req = 600;
    repeat (16) eval_random();
  endtask

  task automatic test_drain_pause();
    gaps_on = 1'b1;
    repeat (10) eval_random();
    drop_valid();
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (10) eval_random();
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_chan.valid         = 1'b0;
    in_chan.func          = FUNC_WRITE;
    in_chan.table_address = '0;
    in_chan.table_word    = '0;
    in_chan.longitude     = '0;
    in_chan.latitude      = '0;
    out_chan.ready        = 1'b0;
    areas_used            = '0;
    foreach (area_words[i]) area_words[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_load();
    test_directed();
    test_random_phases();
    test_output_hold();
    test_drain_pause();
    wait_idle();

    $display("Covered %0d table writes and %0d evaluations (%0d in a region, %0d saturated).",
             n_writes, n_evals, n_hits, n_sat);
    $display("Region counts from 0 to 15, long output stalls and drained pauses included.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
